>>> hw/rtl/sorted_priority_queue_defines.svh
// Assertion macros used by the checker file of the sorted priority queue.
// Depends on nothing; include by bare file name.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sorted priority queue: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sorted priority queue: next-cycle check failed");

`endif

>>> hw/rtl/spq_pkg.sv
// Package of the sorted priority queue: sizes, codes, types.
// Depends on nothing; used by every other file of the block but the defines header.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned POS_W    = 5;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [PRI_W-1:0]        prio_t;

  // Request commands; the unused code falls to the default arm
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } spq_ctrl_t;

endpackage

>>> hw/rtl/spq_intf.sv
// Handshake channels of the sorted priority queue: request and response.
// Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_req_if;
  import spq_pkg::*;
  logic         valid;
  logic         ready;
  logic [1:0]   cmd;
  value_t       item_value;
  prio_t        item_priority;

  modport source (output valid, output cmd, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input cmd, input item_value, input item_priority,
                  output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  value_t             out_value;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   entry_count;

  modport source (output valid, output status, output out_value, output position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input out_value, input position,
                  input entry_count, output ready);
endinterface

>>> hw/rtl/sorted_priority_queue.sv
// Sorted priority queue, 16 entries, smallest priority at the head.
// Each request is captured, then executed over the parallel slot compare into the result
// register; a new request is taken only as the previous result leaves.
// Reset clears the entry count and controller; slot contents are not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .ctrl_o      (ctrl)
  );

  // Slot cells and result
  spq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cmd_i           (req.cmd),
    .item_value_i    (req.item_value),
    .item_priority_i (req.item_priority),
    .status_o        (rsp.status),
    .out_value_o     (rsp.out_value),
    .position_o      (rsp.position),
    .entry_count_o   (rsp.entry_count)
  );

endmodule

>>> hw/rtl/spq_ctrl.sv
// Controller of the sorted priority queue: capture, execute, respond.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output spq_pkg::spq_ctrl_t ctrl_o
);
  import spq_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) state_d = req_valid_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs: take a new request in the cycle the previous result leaves
  always_comb begin
    req_ready_o    = 1'b0;
    rsp_valid_o    = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o    = 1'b1;
        ctrl_o.capture = req_valid_i;
      end
      S_EXEC: begin
        ctrl_o.execute = 1'b1;
      end
      S_RESP: begin
        rsp_valid_o    = 1'b1;
        req_ready_o    = rsp_ready_i;
        ctrl_o.capture = rsp_ready_i && req_valid_i;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue: slot cells, count, compare and result register.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spq_pkg::spq_ctrl_t           ctrl_i,
  input  logic [1:0]                   cmd_i,
  input  spq_pkg::value_t              item_value_i,
  input  spq_pkg::prio_t               item_priority_i,
  output logic [1:0]                   status_o,
  output spq_pkg::value_t              out_value_o,
  output logic [spq_pkg::POS_W-1:0]    position_o,
  output logic [spq_pkg::POS_W-1:0]    entry_count_o
);
  import spq_pkg::*;

  logic [1:0]        req_cmd_q;
  value_t            req_val_q;
  prio_t             req_pri_q;

  value_t            slot_val_q [CAPACITY];
  prio_t             slot_pri_q [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;

  value_t            left_val  [CAPACITY];
  prio_t             left_pri  [CAPACITY];
  value_t            right_val [CAPACITY];
  prio_t             right_pri [CAPACITY];

  logic [CAPACITY-1:0] ge, hit;
  logic [IDX_W-1:0]    ins_idx, hit_idx;
  logic                hit_any, full, empty, do_ins, do_del;

  status_e           status_d;
  value_t            outv_d;
  logic [POS_W-1:0]  pos_d;
  logic [1:0]        status_q;
  value_t            outv_q;
  logic [POS_W-1:0]  pos_q;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_cmd_q <= cmd_i;
      req_val_q <= item_value_i;
      req_pri_q <= item_priority_i;
    end
  end

  // Compare every occupied slot against the request in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i]  = (CNT_W'(i) < count_q) && (slot_pri_q[i] >= req_pri_q);
      hit[i] = (CNT_W'(i) < count_q) && (slot_val_q[i] == req_val_q);
    end
  end

  // Pick the first set flag; an insert with no equal or larger priority goes to the tail
  always_comb begin
    ins_idx = count_q[IDX_W-1:0];
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (ge[i])  ins_idx = IDX_W'(i);
      if (hit[i]) hit_idx = IDX_W'(i);
    end
  end

  assign hit_any = |hit;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);

  // Decode the command into result and update
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    outv_d   = '0;
    pos_d    = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (req_cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_del  = 1'b1;
          outv_d  = slot_val_q[0];
          count_d = count_q - CNT_W'(1);
        end
      end
      CMD_FIND: begin
        if (hit_any) begin
          pos_d = POS_W'(CNT_W'(hit_idx) + CNT_W'(1));
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Neighbours of each cell: the left one feeds a shift back, the right one a shift forward
  always_comb begin
    left_val[0]           = req_val_q;
    left_pri[0]           = req_pri_q;
    right_val[CAPACITY-1] = slot_val_q[CAPACITY-1];
    right_pri[CAPACITY-1] = slot_pri_q[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      left_val[i] = slot_val_q[i-1];
      left_pri[i] = slot_pri_q[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      right_val[i] = slot_val_q[i+1];
      right_pri[i] = slot_pri_q[i+1];
    end
  end

  // Slot cells: hold, take the new entry, shift back from the left or forward from the right
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      for (int g = 0; g < CAPACITY; g++) begin
        if (do_ins && (IDX_W'(g) == ins_idx)) begin
          slot_val_q[g] <= req_val_q;
          slot_pri_q[g] <= req_pri_q;
        end else if (do_ins && (IDX_W'(g) > ins_idx)) begin
          slot_val_q[g] <= left_val[g];
          slot_pri_q[g] <= left_pri[g];
        end else if (do_del) begin
          slot_val_q[g] <= right_val[g];
          slot_pri_q[g] <= right_pri[g];
        end
      end
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.execute) begin
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      status_q <= status_d;
      outv_q   <= outv_d;
      pos_q    <= pos_d;
    end
  end

  assign status_o      = status_q;
  assign out_value_o   = outv_q;
  assign position_o    = pos_q;
  assign entry_count_o = POS_W'(count_q);

endmodule

>>> hw/rtl/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_defines.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module spq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [1:0]                 status_i,
  input spq_pkg::value_t            out_value_i,
  input logic [spq_pkg::POS_W-1:0]  entry_count_i
);
  import spq_pkg::*;

  logic               req_fire;
  logic               rsp_wait;
  logic               rsp_full;
  logic               rsp_empty;
  logic               empty_ok;
  logic [VAL_W+1:0]   rsp_data;

  // Handshake and result terms
  assign req_fire  = req_valid_i && req_ready_i;
  assign rsp_wait  = rsp_valid_i && !rsp_ready_i;
  assign rsp_full  = rsp_valid_i && (status_i == ST_FULL);
  assign rsp_empty = rsp_valid_i && (status_i == ST_EMPTY);
  assign empty_ok  = (entry_count_i == '0) && (out_value_i == '0);
  assign rsp_data  = {status_i, out_value_i};

  // Hold a stalled result
  `SPQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_wait, rsp_valid_i && $stable(rsp_data))
  // A result appears only after a taken request has gone through the execute state
  `SPQ_ASSERT_IMPL(a_rsp_follows_req, clk_i, rst_ni, $rose(rsp_valid_i), $past(req_fire, 2))
  // Accept a new request only as the pending result leaves
  `SPQ_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, req_ready_i && rsp_valid_i, rsp_ready_i)
  // A full rejection reports a full queue
  `SPQ_ASSERT_IMPL(a_full_count, clk_i, rst_ni, rsp_full, entry_count_i == POS_W'(CAPACITY))
  // An empty rejection reports no entries and no value
  `SPQ_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, rsp_empty, empty_ok)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req.valid),
  .req_ready_i   (req.ready),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .status_i      (rsp.status),
  .out_value_i   (rsp.out_value),
  .entry_count_i (rsp.entry_count)
);

>>> tb/sorted_priority_queue_test.sv
// Self-checking testbench of the sorted priority queue: directed corners, then random traffic.
// Depends on spq_pkg, spq_intf.sv and sorted_priority_queue.sv.
// Each result is compared field by field with a local model of the sorted slot store.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  // Request code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct packed {
    status_e          status;
    value_t           out_value;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .rsp    (rsp_ch.source)
  );

  // Model of the queue contents, ascending priority from the head
  value_t        model_values [CAPACITY];
  prio_t         model_prios  [CAPACITY];
  int unsigned   model_count;

  queue_result_t pending_results [$];
  int unsigned   fail_count;
  bit            req_idle_on;
  bit            rsp_stall_on;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Apply one request to the model and return the result it should give
  function automatic queue_result_t predict_queue_result(input logic [1:0] op,
                                                         input value_t val,
                                                         input prio_t prio);
    queue_result_t res;
    int unsigned   at;
    int unsigned   i;
    res.status    = ST_OK;
    res.out_value = '0;
    res.position  = '0;
    case (op)
      CMD_INSERT: begin
        if (model_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // place ahead of the first entry of equal or greater priority
          at = model_count;
          for (i = 0; i < model_count; i++) begin
            if (model_prios[i] >= prio) begin
              at = i;
              break;
            end
          end
          for (i = model_count; i > at; i--) begin
            model_values[i] = model_values[i-1];
            model_prios[i]  = model_prios[i-1];
          end
          model_values[at] = val;
          model_prios[at]  = prio;
          model_count++;
        end
      end
      CMD_DELETE: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_value = model_values[0];
          for (i = 1; i < model_count; i++) begin
            model_values[i-1] = model_values[i];
            model_prios[i-1]  = model_prios[i];
          end
          model_count--;
        end
      end
      CMD_FIND: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < model_count; i++) begin
          if (model_values[i] == val) begin
            res.status   = ST_OK;
            res.position = POS_W'(i + 1);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = POS_W'(model_count);
    return res;
  endfunction

  // Values: small pool for duplicates, extremes, or anything
  function automatic value_t pick_value();
    case ($urandom_range(3))
      0: return value_t'(int'($urandom_range(7)) - 4);
      1: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'shffff;
          default: return 16'sh0000;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  // Priorities: narrow range for ties, extremes, or anything
  function automatic prio_t pick_prio();
    case ($urandom_range(3))
      0: return prio_t'($urandom_range(3));
      1: return $urandom_range(1) ? 8'hff : 8'h00;
      default: return prio_t'($urandom);
    endcase
  endfunction

  // Send one request, with optional idle cycles first, and record its result
  task automatic send_request(input logic [1:0] op, input value_t val, input prio_t prio);
    while (req_idle_on && $urandom_range(99) < 19) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= op;
    req_ch.item_value    <= val;
    req_ch.item_priority <= prio;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_results.push_back(predict_queue_result(op, val, prio));
  endtask

  // Stall the response side at random
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= !(rsp_stall_on && $urandom_range(99) < 19);
    end
  end

  // Compare each result with the oldest outstanding prediction
  always @(posedge clk_i) begin
    queue_result_t exp_res;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding: status %0d value %0d pos %0d cnt %0d",
                 $time, rsp_ch.status, rsp_ch.out_value, rsp_ch.position, rsp_ch.entry_count);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.status !== exp_res.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_res.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.out_value !== exp_res.out_value) begin
          $display("%0t: out_value expected %0d got %0d", $time, exp_res.out_value,
                   rsp_ch.out_value);
          fail_count++;
        end
        if (rsp_ch.position !== exp_res.position) begin
          $display("%0t: position expected %0d got %0d", $time, exp_res.position,
                   rsp_ch.position);
          fail_count++;
        end
        if (rsp_ch.entry_count !== exp_res.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, exp_res.entry_count,
                   rsp_ch.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Empty queue, extremes, tie ordering, duplicates and the unused code
  task automatic test_corner_requests();
    send_request(CMD_DELETE, 16'sh0000, 8'h00);
    send_request(CMD_FIND, 16'sh0000, 8'h00);
    send_request(CMD_UNUSED, 16'shffff, 8'hff);
    send_request(CMD_INSERT, 16'sh7fff, 8'hff);
    send_request(CMD_INSERT, 16'sh8000, 8'h00);
    send_request(CMD_INSERT, 16'sh0000, 8'h80);
    send_request(CMD_INSERT, 16'shffff, 8'h80);
    send_request(CMD_INSERT, 16'sh5a5a, 8'h80);
    send_request(CMD_FIND, 16'sh8000, 8'h00);
    send_request(CMD_FIND, 16'sh7fff, 8'h00);
    send_request(CMD_FIND, 16'sh0000, 8'hff);
    send_request(CMD_FIND, 16'sh1234, 8'h00);
    send_request(CMD_UNUSED, 16'sh55aa, 8'h55);
    send_request(CMD_INSERT, 16'sh8000, 8'hff);
    send_request(CMD_FIND, 16'sh8000, 8'h00);
    repeat (6) send_request(CMD_DELETE, 16'sha5a5, 8'haa);
    send_request(CMD_DELETE, 16'sh0000, 8'h00);
  endtask

  // Fill to capacity, overflow once, then drain past empty
  task automatic test_fill_and_overflow();
    while (model_count < CAPACITY) send_request(CMD_INSERT, pick_value(), pick_prio());
    send_request(CMD_INSERT, 16'sh1234, 8'h00);
    send_request(CMD_FIND, model_values[CAPACITY-1], pick_prio());
    while (model_count != 0) send_request(CMD_DELETE, pick_value(), pick_prio());
    send_request(CMD_DELETE, pick_value(), pick_prio());
  endtask

  // Alternate fill-heavy and drain-heavy phases so the queue swings between full and empty
  task automatic run_mixed_traffic(input int unsigned n_items);
    int unsigned issued;
    int unsigned phase_left;
    int unsigned roll;
    bit          filling;
    logic [1:0]  op;
    value_t      val;
    issued     = 0;
    phase_left = $urandom_range(20, 60);
    filling    = 1'b1;
    while (issued < n_items) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        op = CMD_UNUSED;
      end else if (roll < (filling ? 65 : 22)) begin
        op = CMD_INSERT;
      end else if (roll < 85) begin
        op = CMD_DELETE;
      end else begin
        op = CMD_FIND;
      end
      val = pick_value();
      // look up a stored value half the time so hits are common
      if (op == CMD_FIND && model_count != 0 && $urandom_range(1))
        val = model_values[$urandom_range(model_count - 1)];
      send_request(op, val, pick_prio());
      if (op != CMD_UNUSED) begin
        issued++;
        phase_left--;
        if (phase_left == 0) begin
          filling    = !filling;
          phase_left = $urandom_range(20, 60);
        end
      end
    end
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back_traffic();
    req_idle_on  = 1'b0;
    rsp_stall_on = 1'b0;
    run_mixed_traffic(250);
  endtask

  // Both sides idling at random
  task automatic test_random_idle_traffic();
    req_idle_on  = 1'b1;
    rsp_stall_on = 1'b1;
    run_mixed_traffic(950);
  endtask

  // Main sequence
  initial begin
    int unsigned guard;
    rst_ni               <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= CMD_INSERT;
    req_ch.item_value    <= '0;
    req_ch.item_priority <= '0;
    model_count  = 0;
    fail_count   = 0;
    req_idle_on  = 1'b1;
    rsp_stall_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_requests();
    test_fill_and_overflow();
    test_back_to_back_traffic();
    test_random_idle_traffic();
    req_ch.valid <= 1'b0;

    // Wait for every outstanding result, then let the block settle
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
